// ===== rtl/lzte_pkg.sv =====
// ----------------------------------------------------------------------------
// lzte_pkg
// Shared constants and the command/status types for the LZ77 tuple encoder.
// ----------------------------------------------------------------------------
package lzte_pkg;

    // history store geometry
    localparam int STORE_DEPTH  = 2048;
    localparam int ADDR_W       = 11;

    // payload widths
    localparam int BYTE_W       = 8;
    localparam int DIST_W       = 11;
    localparam int LEN_W        = 6;
    localparam int PEND_W       = 7;
    localparam int TDATA_OUT_W  = 32;

    // parameter defaults
    localparam int DEF_WINDOW    = 1024;
    localparam int DEF_MAX_MATCH = 32;

    // controller to datapath commands
    typedef struct packed {
        logic accept;    // store the incoming byte
        logic setup;     // start a new search
        logic issue;     // compare reads are on the bus
        logic k_inc;     // bytes matched, advance
        logic next_d;    // close this distance, move to the next
        logic sym_rd;    // read the next symbol
        logic sym_cap;   // capture the next symbol
        logic emit;      // load the output register and consume bytes
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic hist_zero;
        logic k_cont;
        logic match;
        logic d_last;
        logic pend_full;
        logic out_free;
        logic flush_more;
    } t_status;

endpackage

// ===== rtl/lz77_tuple_encoder.sv =====
// ----------------------------------------------------------------------------
// lz77_tuple_encoder
// Streaming LZ77 encoder: bytes in, (distance, length, next symbol) tuples out.
// ----------------------------------------------------------------------------
// search: a byte that fills the lookahead, or a final byte, starts a search of
//   the history; a tuple passes setup, then (with a nonempty history) an issue
//   and a compare per byte compared at each distance and a next-distance step,
//   then a symbol read, a symbol capture and the emit, plus any wait on the output register
// throughput: one byte per cycle while no search runs; the search walks the
//   window one byte compare at a time through the store read ports
// reset: synchronous active low, empties the stream; the store needs no clearing
module lz77_tuple_encoder
    import lzte_pkg::*;
#(
    parameter int WINDOW    = DEF_WINDOW,
    parameter int MAX_MATCH = DEF_MAX_MATCH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // data_byte[7:0]
    input  logic                   s_axis_tlast,   // end_of_data
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // distance[10:0], match_length[16:11],
                                                   // next_symbol[24:17], zero pad
    output logic                   m_axis_tlast    // final_tuple
);

    t_cmd              cmd;
    t_status           status;
    logic [DIST_W-1:0] tup_dist;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] sym;

    lzte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    lzte_dp #(.WINDOW(WINDOW), .MAX_MATCH(MAX_MATCH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_dist      (tup_dist),
        .o_len       (len),
        .o_sym       (sym),
        .o_final     (m_axis_tlast)
    );

    // pack the tuple
    assign m_axis_tdata = {(TDATA_OUT_W-DIST_W-LEN_W-BYTE_W)'(0), sym, len, tup_dist};

    // a final byte always starts a flush
    a_last_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken right after final byte");

    // a literal carries no distance
    a_literal_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (len == '0) |-> (tup_dist == '0))
        else $error("literal with nonzero distance");

    // match length stays within the cap
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (len <= LEN_W'(MAX_MATCH)))
        else $error("match length above cap");

endmodule

// ===== rtl/lzte_ram.sv =====
// ----------------------------------------------------------------------------
// lzte_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lzte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/lzte_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzte_ctrl
// Sequencer for byte intake, the window search and tuple emission.
// ----------------------------------------------------------------------------
module lzte_ctrl
    import lzte_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_ISSUE, ST_CMP, ST_NEXT_D, ST_SYM, ST_SYMW, ST_EMIT
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_last || i_status.pend_full) begin
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = i_status.hist_zero ? ST_SYM : ST_ISSUE;
            end
            ST_ISSUE: begin
                if (i_status.k_cont) begin
                    o_cmd.issue = 1'b1;
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_NEXT_D;
                end
            end
            ST_CMP: begin
                if (i_status.match) begin
                    o_cmd.k_inc = 1'b1;
                    n_state = ST_ISSUE;
                end else begin
                    n_state = ST_NEXT_D;
                end
            end
            ST_NEXT_D: begin
                o_cmd.next_d = 1'b1;
                n_state = i_status.d_last ? ST_SYM : ST_ISSUE;
            end
            ST_SYM: begin
                o_cmd.sym_rd = 1'b1;
                n_state = ST_SYMW;
            end
            ST_SYMW: begin
                o_cmd.sym_cap = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = i_status.flush_more ? ST_SETUP : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/lzte_dp.sv =====
// ----------------------------------------------------------------------------
// lzte_dp
// Datapath: history store, stream pointers, match search and output register.
// ----------------------------------------------------------------------------
module lzte_dp
    import lzte_pkg::*;
#(
    parameter int WINDOW    = DEF_WINDOW,
    parameter int MAX_MATCH = DEF_MAX_MATCH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  logic              i_out_ready,
    output t_status           o_status,
    output logic              o_out_valid,
    output logic [DIST_W-1:0] o_dist,
    output logic [LEN_W-1:0]  o_len,
    output logic [BYTE_W-1:0] o_sym,
    output logic              o_final
);

    localparam int CAP = STORE_DEPTH - 1 - MAX_MATCH;
    localparam int EFF = (WINDOW < CAP) ? WINDOW : CAP;
    localparam logic [DIST_W-1:0] EFF_V = DIST_W'(EFF);
    localparam logic [PEND_W-1:0] MAX_V = PEND_W'(MAX_MATCH);

    logic [ADDR_W-1:0] r_wr_pos, r_enc;
    logic [DIST_W-1:0] r_seen, r_d, r_best_dist;
    logic [PEND_W-1:0] r_pend;
    logic [LEN_W-1:0]  r_k, r_best_len;
    logic              r_at_end;
    logic [BYTE_W-1:0] r_sym;
    logic              r_ov;

    logic [BYTE_W-1:0] rd_a, rd_b;
    logic [ADDR_W-1:0] addr_a, addr_b, sym_addr;
    logic [PEND_W-1:0] lim, best_p1, consume, pend_next;
    logic [DIST_W:0]   seen_sum;

    // search arithmetic
    always_comb begin
        lim       = (r_pend < MAX_V) ? r_pend : MAX_V;
        best_p1   = PEND_W'(r_best_len) + PEND_W'(1);
        consume   = (best_p1 > r_pend) ? r_pend : best_p1;
        pend_next = r_pend - consume;
        seen_sum  = {1'b0, r_seen} + (DIST_W+1)'(consume);
        sym_addr  = (PEND_W'(r_best_len) < r_pend) ? r_enc + ADDR_W'(r_best_len)
                                                    : r_enc + ADDR_W'(r_best_len) - 1'b1;
        addr_a    = r_enc - ADDR_W'(r_d) + ADDR_W'(r_k);
        addr_b    = i_cmd.sym_rd ? sym_addr : r_enc + ADDR_W'(r_k);
    end

    lzte_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_hist (
        .i_clk     (i_clk),
        .i_we      (i_cmd.accept),
        .i_waddr   (r_wr_pos),
        .i_wdata   (i_byte),
        .i_raddr_a (addr_a),
        .o_rdata_a (rd_a),
        .i_raddr_b (addr_b),
        .o_rdata_b (rd_b)
    );

    // status back to the controller
    always_comb begin
        o_status.hist_zero  = (r_seen == '0);
        o_status.k_cont     = (PEND_W'(r_k) < lim) && (DIST_W'(r_k) < r_d);
        o_status.match      = (rd_a == rd_b);
        o_status.d_last     = (r_d == r_seen);
        o_status.pend_full  = (r_pend == MAX_V);
        o_status.out_free   = !r_ov || i_out_ready;
        o_status.flush_more = r_at_end && (pend_next != '0);
    end

    // stream pointers and search registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_enc    <= '0;
            r_seen   <= '0;
            r_pend   <= '0;
            r_at_end <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_wr_pos <= r_wr_pos + 1'b1;
                r_pend   <= r_pend + 1'b1;
                r_at_end <= i_last;
            end
            if (i_cmd.emit) begin
                if (r_at_end && pend_next == '0) begin
                    // end of stream: start over with empty history
                    r_wr_pos <= '0;
                    r_enc    <= '0;
                    r_seen   <= '0;
                    r_pend   <= '0;
                    r_at_end <= 1'b0;
                end else begin
                    r_enc  <= r_enc + ADDR_W'(consume);
                    r_pend <= pend_next;
                    r_seen <= (seen_sum > {1'b0, EFF_V}) ? EFF_V : seen_sum[DIST_W-1:0];
                end
            end
        end
    end

    // per-distance match bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_d         <= DIST_W'(1);
            r_k         <= '0;
            r_best_len  <= '0;
            r_best_dist <= '0;
        end
        if (i_cmd.k_inc) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.next_d) begin
            if (r_k > r_best_len) begin
                r_best_len  <= r_k;
                r_best_dist <= r_d;
            end
            r_d <= r_d + 1'b1;
            r_k <= '0;
        end
        if (i_cmd.sym_cap) begin
            r_sym <= rd_b;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_dist  <= r_best_dist;
            o_len   <= r_best_len;
            o_sym   <= r_sym;
            o_final <= r_at_end && (pend_next == '0);
        end
    end

    assign o_out_valid = r_ov;

endmodule
